@@ design/isps_pkg.sv @@
// ----------------------------------------------------------------------------
// isps_pkg: shared types and constants of the power-cycle sequencer
// Phase codes, sync frame pattern, register indexes and inter-module structs.
// ----------------------------------------------------------------------------
package isps_pkg;

  localparam int unsigned FRAME_BITS = 10;
  localparam int unsigned BIT_IDX_W  = 4;
  localparam int unsigned TICK_W     = 20;
  localparam int unsigned HALF_W     = 16;
  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned CFG_IDX_W  = 2;

  // start 0, seven 1s, a 0, stop 1, sent LSB first
  localparam logic [15:0] FRAME_PATTERN = 16'h02FE;

  localparam logic [CFG_IDX_W-1:0] REG_HALF_BIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POWER_OFF = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK     = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_WAIT     = 3'd1,
    PH_SAMPLE   = 3'd2,
    PH_POWEROFF = 3'd3,
    PH_TRANSFER = 3'd4
  } phase_t;

  typedef struct packed {
    logic [HALF_W-1:0] half_bit_ticks;
    logic [TICK_W-1:0] power_off_ticks;
    logic [TICK_W-1:0] blink_ticks;
  } cfg_t;

  typedef struct packed {
    logic       vcc_disable;
    logic       txd_disable;
    logic       led_on;
    logic [2:0] phase_now;
  } result_t;

endpackage

@@ design/isps_seq.sv @@
// ----------------------------------------------------------------------------
// isps_seq: sequencer state and per-tick update
// Holds phase, counters and blink prescaler; advances them on each item and
// presents the result computed from the updated state.
// ----------------------------------------------------------------------------
module isps_seq
  import isps_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    advance,
  input  logic    rts_level,
  input  logic    txd_level,
  input  cfg_t    cfg,
  output result_t result_next
);

  phase_t               phase;
  phase_t               phase_next;
  logic [TICK_W-1:0]    tick_count;
  logic [TICK_W-1:0]    tick_count_next;
  logic [BIT_IDX_W-1:0] bit_index;
  logic [BIT_IDX_W-1:0] bit_index_next;
  logic                 frame_ok;
  logic                 frame_ok_next;
  logic [TICK_W-1:0]    blink_count;
  logic [TICK_W-1:0]    blink_count_next;
  logic                 blink_fast;
  logic                 blink_fast_next;
  logic                 blink_slow;
  logic                 blink_slow_next;

  logic [HALF_W-1:0]    half;
  logic [HALF_W:0]      full_bit;
  logic [TICK_W-1:0]    power_limit;
  logic [TICK_W-1:0]    blink_limit;
  logic [TICK_W-1:0]    tick_inc;
  logic [TICK_W-1:0]    blink_inc;
  logic [BIT_IDX_W-1:0] bit_inc;
  logic                 expect_bit;

  // zero in a register acts as one
  assign half        = (cfg.half_bit_ticks == '0) ? HALF_W'(1) : cfg.half_bit_ticks;
  assign power_limit = (cfg.power_off_ticks == '0) ? TICK_W'(1) : cfg.power_off_ticks;
  assign blink_limit = (cfg.blink_ticks == '0) ? TICK_W'(1) : cfg.blink_ticks;
  assign full_bit    = {half, 1'b0};
  assign tick_inc    = tick_count + TICK_W'(1);
  assign blink_inc   = blink_count + TICK_W'(1);
  assign bit_inc     = bit_index + BIT_IDX_W'(1);
  assign expect_bit  = FRAME_PATTERN[bit_index];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      tick_count  <= '0;
      bit_index   <= '0;
      frame_ok    <= 1'b0;
      blink_count <= '0;
      blink_fast  <= 1'b0;
      blink_slow  <= 1'b0;
    end else if (advance) begin
      phase       <= phase_next;
      tick_count  <= tick_count_next;
      bit_index   <= bit_index_next;
      frame_ok    <= frame_ok_next;
      blink_count <= blink_count_next;
      blink_fast  <= blink_fast_next;
      blink_slow  <= blink_slow_next;
    end
  end

  always_comb begin
    phase_next       = phase;
    tick_count_next  = tick_count;
    bit_index_next   = bit_index;
    frame_ok_next    = frame_ok;
    blink_count_next = blink_inc;
    blink_fast_next  = blink_fast;
    blink_slow_next  = blink_slow;

    // blink prescaler runs in every phase
    if (blink_inc >= blink_limit) begin
      blink_count_next = '0;
      blink_fast_next  = ~blink_fast;
      if (!blink_fast) begin
        blink_slow_next = ~blink_slow;
      end
    end

    case (phase)
      PH_WAIT: begin
        if (rts_level) begin
          phase_next = PH_IDLE;
        end else if (!txd_level) begin
          phase_next      = PH_SAMPLE;
          tick_count_next = '0;
          bit_index_next  = '0;
          frame_ok_next   = 1'b1;
        end
      end
      PH_SAMPLE: begin
        tick_count_next = tick_inc;
        if (tick_inc == TICK_W'(half) && txd_level != expect_bit) begin
          frame_ok_next = 1'b0;
        end
        if (tick_inc >= TICK_W'(full_bit)) begin
          tick_count_next = '0;
          bit_index_next  = bit_inc;
          if (bit_inc >= BIT_IDX_W'(FRAME_BITS)) begin
            bit_index_next = '0;
            if (frame_ok_next) begin
              phase_next = PH_POWEROFF;
            end else begin
              phase_next = PH_TRANSFER;
            end
          end
        end
      end
      PH_POWEROFF: begin
        tick_count_next = tick_inc;
        if (tick_inc >= power_limit) begin
          tick_count_next = '0;
          phase_next      = PH_TRANSFER;
        end
      end
      PH_TRANSFER: begin
        if (rts_level) begin
          phase_next = PH_IDLE;
        end
      end
      default: begin
        // idle, and any stray code behaves as idle
        if (rts_level) begin
          phase_next = PH_IDLE;
        end else begin
          phase_next = PH_WAIT;
        end
      end
    endcase
  end

  always_comb begin
    result_next.vcc_disable = 1'b0;
    result_next.txd_disable = 1'b1;
    result_next.led_on      = 1'b1;
    result_next.phase_now   = phase_next;
    case (phase_next)
      PH_SAMPLE: begin
        result_next.led_on = (tick_count_next < TICK_W'(half));
      end
      PH_POWEROFF: begin
        result_next.vcc_disable = 1'b1;
        result_next.led_on      = blink_fast_next;
      end
      PH_TRANSFER: begin
        result_next.txd_disable = 1'b0;
        result_next.led_on      = blink_slow_next;
      end
      default: begin
        result_next.led_on = 1'b1;
      end
    endcase
  end

endmodule

@@ design/isp_sync_power_cycle_sequencer.sv @@
// ----------------------------------------------------------------------------
// isp_sync_power_cycle_sequencer: power-cycle sequencer for serial ISP
// Watches RTS and TxD samples, detects the 0x7F sync frame, power-cycles
// the target if the frame matches and then passes host TxD through.
//
// Usage:
//   Input channel (in_valid/in_stall): one item per tick carries rts_level
//   and txd_level. Output channel (out_valid/out_stall): one result item per
//   input item, in order, with vcc_disable, txd_disable, led_on, phase_now.
//   The result of an item accepted at a clock edge is registered and shown
//   from the next cycle. Throughput is one item per cycle; the output
//   register lets a new item in while the current result is being taken, so
//   in_stall is high only while a result waits and the receiver stalls.
//   Configuration: cfg_wr_en/cfg_index/cfg_data write half_bit_ticks,
//   power_off_ticks and blink_ticks; write only while no item is in flight.
//   Reset (rst, synchronous) returns to idle with registers at 208, 500000
//   and 100000 ticks, and no result pending; the result payload is not reset.
// ----------------------------------------------------------------------------
module isp_sync_power_cycle_sequencer
  import isps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  rts_level,
  input  logic                  txd_level,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  vcc_disable,
  output logic                  txd_disable,
  output logic                  led_on,
  output logic [2:0]            phase_now,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t    cfg;
  result_t result_next;
  result_t result;
  logic    accept;

  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.half_bit_ticks  <= HALF_W'(208);
      cfg.power_off_ticks <= TICK_W'(500000);
      cfg.blink_ticks     <= TICK_W'(100000);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_HALF_BIT:  cfg.half_bit_ticks  <= cfg_data[HALF_W-1:0];
        REG_POWER_OFF: cfg.power_off_ticks <= cfg_data[TICK_W-1:0];
        REG_BLINK:     cfg.blink_ticks     <= cfg_data[TICK_W-1:0];
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end

  isps_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .advance     (accept),
    .rts_level   (rts_level),
    .txd_level   (txd_level),
    .cfg         (cfg),
    .result_next (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // payload loads only with a new item, so a stalled result holds
  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

  assign vcc_disable = result.vcc_disable;
  assign txd_disable = result.txd_disable;
  assign led_on      = result.led_on;
  assign phase_now   = result.phase_now;

endmodule

@@ design/isps_checker.sv @@
// ----------------------------------------------------------------------------
// isps_checker: port-level checks of the power-cycle sequencer
// Output consistency with phase, a result in the cycle after each accepted item, and the output hold.
// ----------------------------------------------------------------------------
module isps_checker
  import isps_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       vcc_disable,
  input logic       txd_disable,
  input logic       led_on,
  input logic [2:0] phase_now
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(vcc_disable) && $stable(txd_disable)
      && $stable(led_on) && $stable(phase_now))
    else $error("stalled result item changed");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted item gave no result");

  a_vcc: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> vcc_disable == (phase_now == PH_POWEROFF))
    else $error("power off outside power-off phase");

  a_txd: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> txd_disable == (phase_now != PH_TRANSFER))
    else $error("TxD gate disagrees with phase");

endmodule

bind isp_sync_power_cycle_sequencer isps_checker u_isps_checker (.*);
